// ===== sv/apc_pkg.sv =====
// Shared types and constants for the associative page read cache.
`timescale 1ns / 1ps

package apc_pkg;

  localparam int ADDR_W = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT_RD,
    S_FILL,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic store_wr;
    logic capture;
    logic lookup;
    logic take_hit;
    logic fill_rd;
    logic resp_ld;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/apc_ctrl.sv =====
// Request sequencer: lookup, page fill and response hand-off.
`timescale 1ns / 1ps

module apc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  apc_pkg::sts_t sts,
  output apc_pkg::cmd_t cmd
);

  apc_pkg::state_t state_r;
  apc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apc_pkg::S_IDLE: begin
        if (in_valid && (in_kind == apc_pkg::KIND_READ)) begin
          state_nxt = apc_pkg::S_LOOKUP;
        end
      end
      apc_pkg::S_LOOKUP: begin
        state_nxt = sts.hit ? apc_pkg::S_HIT_RD : apc_pkg::S_FILL;
      end
      apc_pkg::S_HIT_RD: begin
        state_nxt = apc_pkg::S_RESP;
      end
      apc_pkg::S_FILL: begin
        if (sts.fill_last) begin
          state_nxt = apc_pkg::S_DRAIN;
        end
      end
      apc_pkg::S_DRAIN: begin
        state_nxt = apc_pkg::S_RESP;
      end
      apc_pkg::S_RESP: begin
        if (sts.out_free) begin
          state_nxt = apc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = apc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      apc_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.store_wr = in_valid && (in_kind == apc_pkg::KIND_LOAD);
        cmd.capture  = in_valid && (in_kind == apc_pkg::KIND_READ);
      end
      apc_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      apc_pkg::S_HIT_RD: begin
        cmd.take_hit = 1'b1;
      end
      apc_pkg::S_FILL: begin
        cmd.fill_rd = 1'b1;
      end
      apc_pkg::S_DRAIN: begin
        cmd = '0;
      end
      apc_pkg::S_RESP: begin
        cmd.resp_ld = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/apc_dp.sv =====
// Datapath: backing store, frame tags and bytes, counters, output register.
`timescale 1ns / 1ps

module apc_dp #(
  parameter int PAGE_BYTES  = 16,
  parameter int FRAME_COUNT = 4,
  parameter int STORE_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  apc_pkg::cmd_t                cmd,
  output apc_pkg::sts_t                sts,
  input  logic [apc_pkg::ADDR_W-1:0]   in_address,
  input  logic [apc_pkg::BYTE_W-1:0]   in_load_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apc_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                         out_was_hit,
  output logic [apc_pkg::CNT_W-1:0]    out_hit_total,
  output logic [apc_pkg::CNT_W-1:0]    out_miss_total
);

  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int SLOT_W = $clog2(FRAME_COUNT);
  localparam int SA_W   = $clog2(STORE_BYTES);
  localparam int AW     = (SA_W < apc_pkg::ADDR_W) ? SA_W : apc_pkg::ADDR_W;
  localparam int TAG_W  = (AW > OFF_W) ? AW - OFF_W : 1;
  localparam int EW     = OFF_W + TAG_W;
  localparam int XW     = (SA_W > apc_pkg::ADDR_W) ? SA_W : apc_pkg::ADDR_W;
  localparam int FW     = (SA_W > EW) ? SA_W : EW;
  localparam int FM_DEPTH = FRAME_COUNT * PAGE_BYTES;
  localparam int FM_W   = SLOT_W + OFF_W;

  logic [apc_pkg::BYTE_W-1:0] st_mem [STORE_BYTES];
  logic [apc_pkg::BYTE_W-1:0] fm_mem [FM_DEPTH];

  logic [AW-1:0]              addr_r;
  logic [TAG_W-1:0]           tag_r [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]     valid_r;
  logic [apc_pkg::CNT_W-1:0]  hit_cnt_r;
  logic [apc_pkg::CNT_W-1:0]  miss_cnt_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [OFF_W-1:0]           fill_idx_r;
  logic [OFF_W-1:0]           wr_idx_r;
  logic                       wr_pend_r;
  logic [apc_pkg::BYTE_W-1:0] st_q_r;
  logic [apc_pkg::BYTE_W-1:0] fm_q_r;
  logic [apc_pkg::BYTE_W-1:0] byte_r;
  logic                       hit_r;
  logic                       out_valid_r;
  logic [apc_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_hit_r;
  logic [apc_pkg::CNT_W-1:0]  out_hit_cnt_r;
  logic [apc_pkg::CNT_W-1:0]  out_miss_cnt_r;

  logic [XW-1:0]              ld_ext;
  logic [SA_W-1:0]            st_wr_addr;
  logic [EW-1:0]              addr_ext;
  logic [TAG_W-1:0]           page_w;
  logic [OFF_W-1:0]           off_w;
  logic [FW-1:0]              fill_full;
  logic [SA_W-1:0]            st_rd_addr;
  logic                       hit;
  logic [SLOT_W-1:0]          hit_idx;
  logic [FM_W-1:0]            fm_rd_addr;
  logic [FM_W-1:0]            fm_wr_addr;
  logic [apc_pkg::CNT_W-1:0]  hit_cnt_nxt;
  logic [apc_pkg::CNT_W-1:0]  miss_cnt_nxt;

  assign ld_ext     = XW'(in_address);
  assign st_wr_addr = ld_ext[SA_W-1:0];
  assign addr_ext   = EW'(addr_r);
  assign page_w     = addr_ext[EW-1:OFF_W];
  assign off_w      = addr_ext[OFF_W-1:0];
  assign fill_full  = FW'({page_w, fill_idx_r});
  assign st_rd_addr = fill_full[SA_W-1:0];
  assign fm_rd_addr = {hit_idx, off_w};
  assign fm_wr_addr = {slot_r, wr_idx_r};

  assign hit_cnt_nxt  = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == page_w)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign sts.hit       = hit;
  assign sts.fill_last = (fill_idx_r == OFF_W'(PAGE_BYTES - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      st_mem[st_wr_addr] <= in_load_byte;
    end
    if (cmd.fill_rd) begin
      st_q_r <= st_mem[st_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      fm_mem[fm_wr_addr] <= st_q_r;
    end
    if (cmd.lookup) begin
      fm_q_r <= fm_mem[fm_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      wr_pend_r <= cmd.fill_rd;
      if (cmd.lookup) begin
        if (hit) begin
          hit_cnt_r <= hit_cnt_nxt;
        end else begin
          miss_cnt_r                       <= miss_cnt_nxt;
          tag_r[miss_cnt_nxt[SLOT_W-1:0]]   <= page_w;
          valid_r[miss_cnt_nxt[SLOT_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.resp_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= ld_ext[AW-1:0];
    end
    if (cmd.lookup) begin
      hit_r      <= hit;
      slot_r     <= miss_cnt_nxt[SLOT_W-1:0];
      fill_idx_r <= '0;
    end else if (cmd.fill_rd) begin
      fill_idx_r <= fill_idx_r + 1'b1;
    end
    wr_idx_r <= fill_idx_r;
    if (cmd.take_hit) begin
      byte_r <= fm_q_r;
    end else if (wr_pend_r && (wr_idx_r == off_w)) begin
      byte_r <= st_q_r;
    end
    if (cmd.resp_ld) begin
      out_byte_r     <= byte_r;
      out_hit_r      <= hit_r;
      out_hit_cnt_r  <= hit_cnt_r;
      out_miss_cnt_r <= miss_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_byte  = out_byte_r;
  assign out_was_hit    = out_hit_r;
  assign out_hit_total  = out_hit_cnt_r;
  assign out_miss_total = out_miss_cnt_r;

endmodule

// ===== sv/assoc_page_read_cache.sv =====
// Top level of the fully associative page read cache.
// Usage:
//   The input channel (in_valid/in_ready) carries one request: in_kind selects
//   a read through the cache or a load of in_load_byte into the backing store.
//   A load is written to the backing store on acceptance and gives no result. A read gives exactly one
//   result on the output channel (out_valid/out_ready): the byte, a hit flag
//   and the saturating hit and miss totals after that read.
//   A read hit passes from lookup, where the frame byte memory's registered read
//   is taken, through the hit byte register to the output register. A read miss
//   fills the page first: the page fill moves one byte a cycle from the
//   backing store port into the frame memory.
//   One request is worked on at a time; in_ready is high only while idle.
//   The result sits in an output register, so a new request is accepted while
//   a result waits; a further read then holds until the receiver takes it.
//   Reset clears the frame valid bits, tags, counters and the output valid flag.
//   PAGE_BYTES, FRAME_COUNT and STORE_BYTES are powers of two.
`timescale 1ns / 1ps

module assoc_page_read_cache #(
  parameter int PAGE_BYTES  = 16,
  parameter int FRAME_COUNT = 4,
  parameter int STORE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic        out_was_hit,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total
);

  apc_pkg::cmd_t cmd;
  apc_pkg::sts_t sts;

  apc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  apc_dp #(
    .PAGE_BYTES  (PAGE_BYTES),
    .FRAME_COUNT (FRAME_COUNT),
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_address     (in_address),
    .in_load_byte   (in_load_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_byte  (out_read_byte),
    .out_was_hit    (out_was_hit),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

endmodule

// ===== sv/apc_checker.sv =====
// Port-level checker for the associative page read cache, with its bind.
`timescale 1ns / 1ps

module apc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_byte,
  input logic        out_was_hit,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_miss_total
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == apc_pkg::KIND_READ) |=> !in_ready)
    else $error("read request accepted while another read is in flight");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_was_hit ? (out_hit_total != 32'd0) : (out_miss_total != 32'd0)))
    else $error("result total does not count its own request");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte)
      && $stable(out_was_hit) && $stable(out_hit_total) && $stable(out_miss_total))
    else $error("result changed while stalled");

endmodule

bind assoc_page_read_cache apc_checker u_apc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_byte  (out_read_byte),
  .out_was_hit    (out_was_hit),
  .out_hit_total  (out_hit_total),
  .out_miss_total (out_miss_total)
);
